// ----- design/lbr_pkg.sv -----
// Shared types and constants for the 2-D lattice basis reduction block.
// Used by lbr_divider and lattice_basis_reduction_2d; depends on nothing.
package lbr_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_REDUCED    = 2'd0;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [1:0] STATUS_LIMIT      = 2'd2;

   localparam int OUT_COORD_W = 32;
   localparam int ROUNDS_W    = 8;
   localparam logic [ROUNDS_W-1:0] ROUND_LIMIT_RESET = 8'd64;

   // Divider handshake status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } lbr_div_stat_type;

endpackage

// ----- design/lattice_basis_reduction_2d.sv -----
// Lagrange-Gauss reduction of a 2-D integer lattice basis; top level.
// Depends on lbr_pkg and lbr_divider.
// An accepted beat runs the norm states S_N1 to S_N7, then each round runs S_L0
// to S_L8 and waits in S_L3 for the serial divider; the round limit ends the
// reduction from S_L0, and S_DONE loads the result register.
// Throughput: one item at a time; the shared multiplier and the bit-serial
// divider set the pace. Synchronous active-high reset sets round_limit to 64.
module lattice_basis_reduction_2d import lbr_pkg::*; #(
   parameter int COORD_BITS = 31
) (
   input  logic clock,
   input  logic reset,
   // fields from bit 0 up: first_x, first_y, second_x, second_y, zero fill
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0 up: short_x, short_y, other_x, other_y, rounds_used
   output logic [4*OUT_COORD_W+ROUNDS_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ROUNDS_W-1:0]               csr_data,
   input  logic                              csr_valid,
   output logic                              csr_ready
);
   // Internal coordinate width: one bit above the input so that reduced
   // vectors (which never lengthen beyond the input range) always fit.
   localparam int IW = COORD_BITS + 1;
   // Quotient width: |q| is at most |b|/|a| + 1.
   localparam int QW = IW + 2;
   localparam int PW = QW + IW;       // multiplier product
   localparam int AW = PW + 1;        // norms, dot, cross
   localparam int DW = AW + 1;        // divider operands

   localparam logic [4:0] S_IDLE = 5'd0,  S_N1 = 5'd1,  S_N2 = 5'd2,
                          S_N3 = 5'd3,  S_N4 = 5'd4,  S_N5 = 5'd5,
                          S_N6 = 5'd6,  S_N7 = 5'd7,  S_L0 = 5'd8,
                          S_L1 = 5'd9,  S_L2 = 5'd10, S_L3 = 5'd11,
                          S_L4 = 5'd12, S_L5 = 5'd13, S_L6 = 5'd14,
                          S_L7 = 5'd15, S_L8 = 5'd16, S_DONE = 5'd17;

   logic [4:0] state_ff, state_in;

   logic signed [IW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [IW-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [AW-1:0] acc_ff, acc_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [QW-1:0] q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic [ROUNDS_W-1:0]  rounds_ff, rounds_in, limit_ff;
   logic [1:0]           status_ff, status_in;

   // Shared multiplier: operands chosen by the sequencer, product registered.
   logic signed [QW-1:0] mul_a;
   logic signed [IW-1:0] mul_b;
   logic signed [PW-1:0] prod_ff;

   // Divider hookup.
   logic             div_start;
   logic [DW-1:0]    div_num, div_den, div_quo;
   lbr_div_stat_type div_stat;

   logic signed [AW-1:0] sum, diff, dot_mag;
   logic signed [AW-1:0] prod_w;
   logic signed [PW-1:0] bsub_x, bsub_y;

   // Output register.
   logic                              rsp_valid_ff;
   logic [4*OUT_COORD_W+ROUNDS_W-1:0] rsp_data_ff;
   logic [1:0]                        rsp_user_ff;

   lbr_divider #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   assign prod_w  = AW'(prod_ff);
   assign sum     = acc_ff + prod_w;
   assign diff    = acc_ff - prod_w;
   assign dot_mag = sum[AW-1] ? -sum : sum;
   assign bsub_x  = PW'(bx_ff) - prod_ff;
   assign bsub_y  = PW'(by_ff) - prod_ff;

   // Rounded quotient: (2|dot| + na) / (2 na), half away from zero.
   assign div_num = {dot_mag[AW-1:0], 1'b0} + DW'(na_ff);
   assign div_den = {na_ff[AW-1:0], 1'b0};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      mul_a = QW'(ax_ff);
      mul_b = ax_ff;
      unique case (state_ff)
         S_N1:    begin mul_a = QW'(ax_ff); mul_b = ax_ff; end
         S_N2:    begin mul_a = QW'(ay_ff); mul_b = ay_ff; end
         S_N3:    begin mul_a = QW'(bx_ff); mul_b = bx_ff; end
         S_N4:    begin mul_a = QW'(by_ff); mul_b = by_ff; end
         S_N5:    begin mul_a = QW'(ax_ff); mul_b = by_ff; end
         S_N6:    begin mul_a = QW'(ay_ff); mul_b = bx_ff; end
         S_L0:    begin mul_a = QW'(ax_ff); mul_b = bx_ff; end
         S_L1:    begin mul_a = QW'(ay_ff); mul_b = by_ff; end
         S_L4:    begin mul_a = q_ff;       mul_b = ax_ff; end
         S_L5:    begin mul_a = q_ff;       mul_b = ay_ff; end
         S_L6:    begin mul_a = QW'(bx_ff); mul_b = bx_ff; end
         S_L7:    begin mul_a = QW'(by_ff); mul_b = by_ff; end
         default: begin mul_a = QW'(ax_ff); mul_b = ax_ff; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      acc_in    = acc_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      rounds_in = rounds_ff;
      status_in = status_ff;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ax_in     = IW'(signed'(req_tdata[0*COORD_BITS +: COORD_BITS]));
               ay_in     = IW'(signed'(req_tdata[1*COORD_BITS +: COORD_BITS]));
               bx_in     = IW'(signed'(req_tdata[2*COORD_BITS +: COORD_BITS]));
               by_in     = IW'(signed'(req_tdata[3*COORD_BITS +: COORD_BITS]));
               rounds_in = '0;
               state_in  = S_N1;
            end
         end
         S_N1: state_in = S_N2;
         S_N2: begin acc_in = prod_w; state_in = S_N3; end
         S_N3: begin na_in = sum;     state_in = S_N4; end
         S_N4: begin acc_in = prod_w; state_in = S_N5; end
         S_N5: begin nb_in = sum;     state_in = S_N6; end
         S_N6: begin acc_in = prod_w; state_in = S_N7; end
         S_N7: begin
            // Put the shorter vector first; a tie keeps the input order.
            if (na_ff > nb_ff) begin
               ax_in = bx_ff; ay_in = by_ff;
               bx_in = ax_ff; by_in = ay_ff;
               na_in = nb_ff; nb_in = na_ff;
            end
            // A zero cross product covers zero vectors as well.
            if (diff == '0) begin
               status_in = STATUS_DEGENERATE;
               state_in  = S_DONE;
            end else begin
               state_in = S_L0;
            end
         end
         S_L0: begin
            if (rounds_ff >= limit_ff) begin
               status_in = STATUS_LIMIT;
               state_in  = S_DONE;
            end else begin
               state_in = S_L1;
            end
         end
         S_L1: begin acc_in = prod_w; state_in = S_L2; end
         S_L2: begin
            neg_in    = sum[AW-1];
            div_start = 1'b1;
            state_in  = S_L3;
         end
         S_L3: begin
            if (div_stat.done) begin
               q_in     = neg_ff ? -signed'(div_quo[QW-1:0]) : signed'(div_quo[QW-1:0]);
               state_in = S_L4;
            end
         end
         S_L4: state_in = S_L5;
         S_L5: begin bx_in = bsub_x[IW-1:0]; state_in = S_L6; end
         S_L6: begin by_in = bsub_y[IW-1:0]; state_in = S_L7; end
         S_L7: begin acc_in = prod_w; state_in = S_L8; end
         S_L8: begin
            rounds_in = rounds_ff + 1'b1;
            if (sum < na_ff) begin
               ax_in = bx_ff; ay_in = by_ff;
               bx_in = ax_ff; by_in = ay_ff;
               na_in = sum;
               state_in = S_L0;
            end else begin
               status_in = STATUS_REDUCED;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= ROUND_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      acc_ff    <= acc_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      q_ff      <= q_in;
      neg_ff    <= neg_in;
      rounds_ff <= rounds_in;
      status_ff <= status_in;
      prod_ff   <= PW'(mul_a) * PW'(mul_b);
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {rounds_ff,
                         OUT_COORD_W'(by_ff), OUT_COORD_W'(bx_ff),
                         OUT_COORD_W'(ay_ff), OUT_COORD_W'(ax_ff)};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- design/lbr_divider.sv -----
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// Depends on lbr_pkg for its status struct.
module lbr_divider import lbr_pkg::*; #(
   parameter int DW = 68
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     num,
   input  logic [DW-1:0]     den,
   output logic [DW-1:0]     quo,
   output lbr_div_stat_type  stat
);
   localparam int CW = $clog2(DW + 1);

   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_sh;
   logic          fits;

   assign rem_sh = {rem_ff[DW-1:0], quo_ff[DW-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for lattice_basis_reduction_2d (2-D Lagrange-Gauss reduction).
// Depends on lbr_pkg and the RTL of the block. Has its own predictor of the reduced basis.
`timescale 1ns / 100ps

module testbench import lbr_pkg::*;;

   localparam int COORD_BITS = 31;
   localparam int REQ_W = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_W = 4*OUT_COORD_W+ROUNDS_W;
   localparam longint CYCLE_LIMIT = 40000000;

   typedef struct {
      logic signed [31:0] short_x;
      logic signed [31:0] short_y;
      logic signed [31:0] other_x;
      logic signed [31:0] other_y;
      logic [7:0]         rounds_used;
      logic [1:0]         status;
   } basis_result_type;

   logic                clock;
   logic                reset;
   logic [REQ_W-1:0]    req_tdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [RSP_W-1:0]    rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [ROUNDS_W-1:0] csr_data;
   logic                csr_valid;
   logic                csr_ready;

   // The predictor's copy of the one register.
   logic [7:0]       round_limit_now;
   basis_result_type pending_bases[$];
   int               error_count;
   int               beats_sent;
   int               beats_checked;
   int               limit_hits;
   int               degenerate_hits;
   int               max_rounds_seen;
   longint           cycle_count;
   int               burst_left;
   int               ready_hold;

   lattice_basis_reduction_2d #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Exact integer reduction. The shorter vector is put first (the first one wins a
   // tie), then each round subtracts the rounded multiple of the first vector from
   // the second and swaps while the second keeps getting shorter.
   function automatic basis_result_type reduce_basis(input longint ax, input longint ay,
                                                     input longint bx, input longint by,
                                                     input logic [7:0] limit);
      longint           na, nb, t, q, dot;
      longint unsigned  mag, den, uq;
      int               rounds;
      logic [1:0]       st;
      basis_result_type r;
      na = ax*ax + ay*ay;
      nb = bx*bx + by*by;
      rounds = 0;
      if (na > nb) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
         t = na; na = nb; nb = t;
      end
      if (na == 0 || nb == 0 || ax*by - ay*bx == 0) begin
         st = STATUS_DEGENERATE;
      end else begin
         while (1) begin
            if (rounds >= limit) begin
               st = STATUS_LIMIT;
               break;
            end
            // Rounding is half away from zero on the magnitude.
            dot = ax*bx + ay*by;
            mag = (dot < 0) ? -dot : dot;
            den = na;
            uq = (2*mag + den) / (2*den);
            q = (dot < 0) ? -longint'(uq) : longint'(uq);
            bx = bx - q*ax;
            by = by - q*ay;
            nb = bx*bx + by*by;
            rounds++;
            if (nb < na) begin
               t = ax; ax = bx; bx = t;
               t = ay; ay = by; by = t;
               t = na; na = nb; nb = t;
            end else begin
               st = STATUS_REDUCED;
               break;
            end
         end
      end
      r.short_x = ax[31:0];
      r.short_y = ay[31:0];
      r.other_x = bx[31:0];
      r.other_y = by[31:0];
      r.rounds_used = rounds[7:0];
      r.status = st;
      return r;
   endfunction

   // Sends one beat. The sender runs in bursts; valid only drops at the end of one.
   task automatic send_basis(input logic signed [30:0] ax, input logic signed [30:0] ay,
                             input logic signed [30:0] bx, input logic signed [30:0] by);
      int gap;
      req_tdata  <= {{(REQ_W-4*COORD_BITS){1'b0}}, by, bx, ay, ax};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_bases = {pending_bases, reduce_basis(ax, ay, bx, by, round_limit_now)};
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_bases.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with the block idle; one result per item, so a short
   // pause after the last result is enough.
   task automatic write_round_limit(input logic [7:0] value);
      stop_sending();
      wait_drained();
      repeat (20) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      round_limit_now = value;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   // Result side: checks every beat and stalls on its own pattern. A long hold-off
   // is requested through ready_hold.
   initial begin : result_checker
      basis_result_type want;
      int               mode;
      int               mode_left;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_bases.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               want = pending_bases.pop_front();
               check_field("short_x", want.short_x, rsp_tdata[31:0]);
               check_field("short_y", want.short_y, rsp_tdata[63:32]);
               check_field("other_x", want.other_x, rsp_tdata[95:64]);
               check_field("other_y", want.other_y, rsp_tdata[127:96]);
               check_field("rounds_used", want.rounds_used, rsp_tdata[135:128]);
               check_field("status", want.status, rsp_tuser);
               beats_checked++;
               if (want.status == STATUS_LIMIT) limit_hits++;
               if (want.status == STATUS_DEGENERATE) degenerate_hits++;
               if (want.rounds_used > max_rounds_seen) max_rounds_seen = want.rounds_used;
            end
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_tready <= 1'b0;
         end else if (mode == 0) begin
            rsp_tready <= 1'b1;
         end else if (mode == 1) begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end else begin
            rsp_tready <= (cycle_count % 5 < 2);
         end
      end
   end

   function automatic logic signed [30:0] rand_coord(input int bits);
      logic signed [30:0] v;
      v = 31'($urandom());
      if (bits < 31) v = v >>> (31 - bits);
      return v;
   endfunction

   // A deep sequence: start from a small basis and stack random unimodular steps on
   // it, so the block needs many rounds to undo them.
   task automatic send_deep_basis();
      longint ux, uy, vx, vy, t, k;
      ux = $signed($urandom_range(0, 40)) - 20;
      uy = $signed($urandom_range(0, 40)) - 20;
      vx = $signed($urandom_range(0, 40)) - 20;
      vy = $signed($urandom_range(0, 40)) - 20;
      repeat ($urandom_range(1, 40)) begin
         k = $urandom_range(1, 3);
         if ($urandom_range(0, 1)) k = -k;
         t = vx + k*ux;
         if (t > (1 << 28) || t < -(1 << 28)) break;
         t = vy + k*uy;
         if (t > (1 << 28) || t < -(1 << 28)) break;
         vx = vx + k*ux;
         vy = vy + k*uy;
         t = ux; ux = vx; vx = t;
         t = uy; uy = vy; vy = t;
      end
      send_basis(31'(ux), 31'(uy), 31'(vx), 31'(vy));
   endtask

   task automatic send_random_item();
      int                 kind;
      int                 bits;
      longint             k;
      logic signed [30:0] ax, ay;
      kind = $urandom_range(0, 9);
      bits = $urandom_range(2, 31);
      if (kind < 6) begin
         send_deep_basis();
      end else if (kind < 8) begin
         send_basis(rand_coord(bits), rand_coord(bits), rand_coord(bits), rand_coord(bits));
      end else if (kind == 8) begin
         // Dependent pair, the second a small multiple of the first.
         ax = rand_coord(bits > 27 ? 27 : bits);
         ay = rand_coord(bits > 27 ? 27 : bits);
         k = $signed($urandom_range(0, 14)) - 7;
         send_basis(ax, ay, 31'(ax*k), 31'(ay*k));
      end else begin
         if ($urandom_range(0, 1))
            send_basis(0, 0, rand_coord(bits), rand_coord(bits));
         else
            send_basis(rand_coord(bits), rand_coord(bits), 0, 0);
      end
   endtask

   // Extremes, zero and dependent vectors, a length tie and a long Fibonacci chain.
   task automatic test_directed();
      logic signed [30:0] lo, hi;
      lo = 31'sh4000_0000;
      hi = 31'sh3fff_ffff;
      send_basis(0, 0, 0, 0);
      send_basis(0, 0, 5, 7);
      send_basis(3, -4, 0, 0);
      send_basis(2, 3, 4, 6);
      send_basis(lo, lo, hi, hi);
      send_basis(lo, 0, 0, lo);
      send_basis(hi, 0, 0, hi);
      send_basis(lo, hi, hi, lo);
      send_basis(hi, lo, lo, lo);
      send_basis(lo, hi, lo, lo);
      send_basis(hi, hi, hi, 31'(hi - 1));
      send_basis(-1, -1, 1, 1);
      send_basis(5, 0, 0, 5);
      send_basis(3, 4, 4, 3);
      send_basis(1, 0, 2, 1);
      send_basis(1, 0, 3, 1);
      send_basis(-1, 0, 5, 1);
      send_basis(701408733, 433494437, 433494437, 267914296);
      send_basis(433494437, 267914296, 701408733, 433494437);
      send_basis(1, 1000, 0, 1);
      send_basis(lo, 1, 31'(lo + 1), 1);
      send_basis(31'sh2aaa_aaaa, 31'sh5555_5555, 31'sh1234_5678, 31'sh6edc_ba98);
      stop_sending();
   endtask

   task automatic test_round_limits();
      logic [7:0] limits[5];
      limits = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd64};
      foreach (limits[i]) begin
         write_round_limit(limits[i]);
         send_basis(701408733, 433494437, 433494437, 267914296);
         send_basis(0, 0, 9, 9);
         repeat (6) send_random_item();
      end
      stop_sending();
   endtask

   // Receiver holds off for a long time while the sender keeps offering beats.
   task automatic test_backpressure();
      ready_hold = 10000;
      repeat (12) send_random_item();
      stop_sending();
   endtask

   task automatic test_pause_until_drained();
      repeat (8) send_random_item();
      stop_sending();
      wait_drained();
      repeat (8) send_random_item();
      stop_sending();
   endtask

   task automatic test_random(input int count, input logic [7:0] limit);
      write_round_limit(limit);
      repeat (count) send_random_item();
      stop_sending();
   endtask

   initial begin
      reset = 1'b1;
      req_tdata = '0;
      req_tvalid = 1'b0;
      csr_data = '0;
      csr_valid = 1'b0;
      round_limit_now = ROUND_LIMIT_RESET;
      error_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      limit_hits = 0;
      degenerate_hits = 0;
      max_rounds_seen = 0;
      ready_hold = 0;
      burst_left = $urandom_range(1, 8);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_round_limits();
      test_backpressure();
      test_pause_until_drained();
      test_random(120, 8'd64);
      test_random(40, 8'd3);
      test_random(40, 8'd255);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d items, %0d results checked: %0d degenerate, %0d at the round limit",
               beats_sent, beats_checked, degenerate_hits, limit_hits);
      $display("round limits 0, 1, 2, 3, 64 and 255; deepest reduction took %0d rounds",
               max_rounds_seen);
      if (error_count == 0 && pending_bases.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/lbr_pkg.sv
design/lbr_divider.sv
design/lattice_basis_reduction_2d.sv
sim/testbench.sv
